### hw/rtl/npc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_pkg: shared types and constants of the nearest palette color search
// Holds the controller states, the command and status groups that join the
// controller and the datapath, and the fixed field widths.
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam int COMP_W  = 8;
  localparam int INDEX_W = 8;
  localparam int END_W   = 9;
  localparam int DIST_W  = 18;
  localparam int BOUND_W = 13;  // Holds any palette size up to 4096.

  // Largest possible squared distance, reported for an empty range.
  localparam logic [DIST_W-1:0] MAX_DISTANCE = 18'd195075;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic wr;
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic is_search;
    logic range_empty;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/npc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_if: request and response channels
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface npc_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] first_index;
  logic [8:0] end_index;

  modport source (output valid, req_type, entry_index, red, green, blue,
                  first_index, end_index, input ready);
  modport sink   (input valid, req_type, entry_index, red, green, blue,
                  first_index, end_index, output ready);
endinterface

interface npc_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  best_index;
  logic [17:0] best_distance;
  logic        exact_match;

  modport source (output valid, best_index, best_distance, exact_match,
                  input ready);
  modport sink   (input valid, best_index, best_distance, exact_match,
                  output ready);
endinterface

### hw/rtl/npc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module npc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hw/rtl/npc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_ctrl: controller of the palette search
// Sequences accept, scan, drain of the last read, and result hand-off.
// ----------------------------------------------------------------------------
module npc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  npc_pkg::sts_t sts,
  output npc_pkg::cmd_t cmd
);
  import npc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          if (sts.is_search) begin
            cmd.load   = 1'b1;
            state_next = sts.range_empty ? ST_FINISH : ST_SCAN;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/npc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_datapath: palette memory, scan counter, distance unit and best tracker
// Computes one squared RGB distance per cycle and holds the result register.
// ----------------------------------------------------------------------------
module npc_datapath #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  npc_pkg::cmd_t cmd,
  output npc_pkg::sts_t sts,
  npc_req_if.sink       req,
  npc_rsp_if.source     rsp
);
  import npc_pkg::*;

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [BOUND_W-1:0] ENTRIES_B = BOUND_W'(PALETTE_ENTRIES);

  logic [COMP_W-1:0]  tgt_red, tgt_green, tgt_blue;
  logic [END_W-1:0]   cur, end_eff;
  logic               rd_pend;
  logic [INDEX_W-1:0] rd_idx;
  logic [INDEX_W-1:0] best_idx;
  logic [DIST_W-1:0]  best_dist;
  logic               found;
  logic               out_valid;
  logic [INDEX_W-1:0] out_idx;
  logic [DIST_W-1:0]  out_dist;

  logic [BOUND_W-1:0] end_b, cur_b, wr_b;
  logic [END_W-1:0]   end_clamp;
  logic               wr_in_range;
  logic [AW-1:0]      ram_addr;
  logic [23:0]        ram_wdata, ram_rdata;
  logic [DIST_W-1:0]  cand_dist;

  // Clamp the range end to the palette size.
  assign end_b       = BOUND_W'(req.end_index);
  assign end_clamp   = (end_b > ENTRIES_B) ? ENTRIES_B[END_W-1:0] : req.end_index;
  assign wr_b        = BOUND_W'(req.entry_index);
  assign wr_in_range = wr_b < ENTRIES_B;
  assign cur_b       = BOUND_W'(cur);

  assign ram_addr  = cmd.wr ? wr_b[AW-1:0] : cur_b[AW-1:0];
  assign ram_wdata = {req.red, req.green, req.blue};

  npc_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr && wr_in_range),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

  assign cand_dist = DIST_W'(sq_diff(tgt_red,   ram_rdata[23:16]))
                   + DIST_W'(sq_diff(tgt_green, ram_rdata[15:8]))
                   + DIST_W'(sq_diff(tgt_blue,  ram_rdata[7:0]));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt_red   <= req.red;
      tgt_green <= req.green;
      tgt_blue  <= req.blue;
      cur       <= END_W'(req.first_index);
      end_eff   <= end_clamp;
      best_idx  <= req.first_index;
      best_dist <= MAX_DISTANCE;
    end else begin
      if (cmd.scan) begin
        cur <= cur + END_W'(1);
      end
      if (rd_pend && (!found || cand_dist < best_dist)) begin
        best_idx  <= rd_idx;
        best_dist <= cand_dist;
      end
    end
    if (cmd.scan) begin
      rd_idx <= cur[INDEX_W-1:0];
    end
    if (cmd.finish) begin
      out_idx  <= best_idx;
      out_dist <= best_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= cmd.scan;
      if (cmd.load) begin
        found <= 1'b0;
      end else if (rd_pend) begin
        found <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.in_valid    = req.valid;
  assign sts.is_search   = req.req_type == REQ_SEARCH;
  assign sts.range_empty = END_W'(req.first_index) >= end_clamp;
  assign sts.scan_last   = (cur + END_W'(1)) == end_eff;
  assign sts.out_free    = !out_valid || rsp.ready;

  assign req.ready         = cmd.in_ready;
  assign rsp.valid         = out_valid;
  assign rsp.best_index    = out_idx;
  assign rsp.best_distance = out_dist;
  assign rsp.exact_match   = out_dist == '0;

endmodule

### hw/rtl/nearest_palette_color.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color: nearest RGB palette entry search
// Palette memory loaded by write words; search words return the closest entry.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one word per request. With req_type at write, the
//   word loads red, green and blue into palette entry entry_index (entries at
//   or above PALETTE_ENTRIES are ignored); a write gives no response and the
//   block stays idle. With req_type at search, the block scans the entries in
//   [first_index, end_index), end clamped to PALETTE_ENTRIES, and returns on
//   the rsp channel the lowest index of smallest squared RGB distance, that
//   distance, and exact_match when it is zero. An empty range returns
//   first_index with the largest distance.
//   A search over a non-empty range scans its entries in order, reading the
//   single palette memory port once per cycle, drains the registered read of
//   the last entry, then loads the output register when it is free; an empty
//   range goes from the accept straight to that load. ready is high again in
//   the cycle the response appears.
//   A new word may be accepted while a response still waits in the output
//   register; a stalled receiver only holds the following search at its end.
//   Entries must be written before a search reads them. Reset (rst,
//   synchronous) returns the controller to idle and drops any pending
//   response; the palette contents are not cleared.
// ----------------------------------------------------------------------------
module nearest_palette_color #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic      clk,
  input  logic      rst,
  npc_req_if.sink   req,
  npc_rsp_if.source rsp
);
  import npc_pkg::*;

  // The controller and the datapath talk only through these two groups.
  cmd_t cmd;
  sts_t sts;

  npc_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // The datapath owns the palette memory, the scan counter, the distance
  // unit and the result register that decouples the response side.
  npc_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .req (req),
    .rsp (rsp)
  );

endmodule
